/* src/jbr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jbr_pkg
// Shared widths, register codes and types of the jitter buffer resampler.
// ----------------------------------------------------------------------------
package jbr_pkg;

    // ring geometry
    localparam int CAPACITY  = 16384;
    localparam int PTR_W     = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);

    // fixed field widths
    localparam int SAMPLE_W  = 16;
    localparam int STEP_W    = 19;
    localparam int LVL_W     = 15;
    localparam int CMP_W     = (CNT_W > LVL_W) ? CNT_W : LVL_W;

    // phase arithmetic, unsigned fixed point with FRAC_BITS fraction bits
    localparam int FRAC_BITS = 16;
    localparam int PHASE_W   = 48;
    localparam int INT_W     = PHASE_W - FRAC_BITS;
    localparam int DIFF_W    = SAMPLE_W + 1;
    // phase bits that can still give an in-range interpolation result
    localparam int MUL_PH_W  = FRAC_BITS + DIFF_W;
    localparam int PROD_W    = DIFF_W + MUL_PH_W + 1;
    localparam int PART_W    = PROD_W - FRAC_BITS;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    // stream and register port widths
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 32;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = STEP_W;

    // action codes
    localparam logic ACT_PUSH   = 1'b0;
    localparam logic ACT_OUTPUT = 1'b1;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_STEP_NOMINAL    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_STEP_SLOW       = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_STEP_FAST       = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_LOW_FILL        = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_HIGH_FILL       = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_PREBUFFER_LEVEL = 3'd5;

    // register reset values
    localparam logic [STEP_W-1:0] STEP_NOMINAL_RST    = 19'd10923;
    localparam logic [STEP_W-1:0] STEP_SLOW_RST       = 19'd10813;
    localparam logic [STEP_W-1:0] STEP_FAST_RST       = 19'd11032;
    localparam logic [LVL_W-1:0]  LOW_FILL_RST        = 15'd160;
    localparam logic [LVL_W-1:0]  HIGH_FILL_RST       = 15'd5000;
    localparam logic [LVL_W-1:0]  PREBUFFER_LEVEL_RST = 15'd320;

    // per-word information handed from the control unit to the datapath
    typedef struct packed {
        logic                 valid;
        logic [PHASE_W-1:0]   phase;
        logic [LVL_W-1:0]     fill;
        logic                 primed;
    } item_info_t;

    // control state visible at the top level
    typedef struct packed {
        logic [CNT_W-1:0]     fill;
        logic                 primed;
        logic                 block_active;
    } ctrl_status_t;

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(CAPACITY - 1)) ? '0 : p + PTR_W'(1);
    endfunction

endpackage

/* src/jitter_buffer_linear_resampler_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jitter_buffer_linear_resampler_top
// Single-talker playback jitter buffer with a linear interpolation resampler.
// ----------------------------------------------------------------------------
//  port group   dir  contents
//  s_*          in   push a sample (s_tuser = 0) or request an output (= 1)
//  m_*          out  one result word per input word
//  cfg_*        in   register writes, index 0..5
//
//  one word per cycle sustained while m_tready does not hold the pipeline;
//  a result passes the ring read, product (multiply) and output (saturate)
//  registers before it is up on m_tvalid
//  the ring memory is written or read once per word and its read port sets
//  the pace together with the phase and pointer update in the control unit
//  reset clears pointers, fill count, phase, flags and the pipeline and
//  restores register defaults; ring contents are left as they are
//  with m_tready low the pipeline keeps taking words until three are held
// ----------------------------------------------------------------------------
module jitter_buffer_linear_resampler_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [jbr_pkg::S_TDATA_W-1:0]     s_tdata,   // pcm_in, first_of_block
    input  logic                              s_tuser,   // action
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [jbr_pkg::M_TDATA_W-1:0]     m_tdata,   // out_sample, fill_level, is_primed
    output logic                              m_tuser,   // out_valid
    input  logic                              cfg_we,
    input  logic [jbr_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [jbr_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import jbr_pkg::*;

    logic                in_accept;
    logic                wr_en;
    logic [PTR_W-1:0]    wr_addr;
    logic [SAMPLE_W-1:0] wr_data;
    logic                rd_en;
    logic [PTR_W-1:0]    rd_addr0, rd_addr1;
    logic [SAMPLE_W-1:0] rd_data0, rd_data1;
    item_info_t          item;
    ctrl_status_t        status;
    logic                out_valid;
    logic [SAMPLE_W-1:0] out_sample;
    logic [LVL_W-1:0]    out_fill;
    logic                out_primed;

    assign in_accept = s_tvalid && s_tready;

    jbr_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_accept (in_accept),
        .in_action (s_tuser),
        .in_pcm    (s_tdata[SAMPLE_W-1:0]),
        .in_last   (s_tlast),
        .in_first  (s_tdata[SAMPLE_W]),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr0  (rd_addr0),
        .rd_addr1  (rd_addr1),
        .item      (item),
        .status    (status)
    );

    jbr_ring_ram u_ring (
        .aclk     (aclk),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd_en    (rd_en),
        .rd_addr0 (rd_addr0),
        .rd_addr1 (rd_addr1),
        .rd_data0 (rd_data0),
        .rd_data1 (rd_data1)
    );

    jbr_interp u_interp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_accept  (in_accept),
        .item       (item),
        .rd_data0   (rd_data0),
        .rd_data1   (rd_data1),
        .in_ready   (s_tready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .out_valid  (out_valid),
        .out_sample (out_sample),
        .out_fill   (out_fill),
        .out_primed (out_primed)
    );

    assign m_tuser = out_valid;
    assign m_tdata = {out_primed, out_fill, out_sample};

    // a mix block only runs on a primed buffer
    assert property (@(posedge aclk) disable iff (!aresetn)
        status.block_active |-> status.primed)
        else $error("block active while buffer not primed");

    assert property (@(posedge aclk) disable iff (!aresetn)
        status.fill <= CNT_W'(CAPACITY))
        else $error("fill count above ring capacity");

    // input side only stalls behind a blocked full pipeline
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled with room in the pipeline");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> m_tdata[M_TDATA_W-1])
        else $error("interpolated word from an unprimed buffer");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata[SAMPLE_W-1:0] == '0))
        else $error("nonzero sample on a word without output");

endmodule

/* src/jbr_ring_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jbr_ring_ram
// Sample ring: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module jbr_ring_ram (
    input  logic                          aclk,
    input  logic                          wr_en,
    input  logic [jbr_pkg::PTR_W-1:0]     wr_addr,
    input  logic [jbr_pkg::SAMPLE_W-1:0]  wr_data,
    input  logic                          rd_en,
    input  logic [jbr_pkg::PTR_W-1:0]     rd_addr0,
    input  logic [jbr_pkg::PTR_W-1:0]     rd_addr1,
    output logic [jbr_pkg::SAMPLE_W-1:0]  rd_data0,
    output logic [jbr_pkg::SAMPLE_W-1:0]  rd_data1
);
    import jbr_pkg::*;

    logic [SAMPLE_W-1:0] mem [CAPACITY];
    logic [SAMPLE_W-1:0] rd_data0_reg;
    logic [SAMPLE_W-1:0] rd_data1_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data0_reg <= mem[rd_addr0];
            rd_data1_reg <= mem[rd_addr1];
        end
    end

    assign rd_data0 = rd_data0_reg;
    assign rd_data1 = rd_data1_reg;

endmodule

/* src/jbr_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jbr_ctrl
// Register file, ring pointers, fill count, phase and block state.
// ----------------------------------------------------------------------------
module jbr_ctrl (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [jbr_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [jbr_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            in_accept,
    input  logic                            in_action,
    input  logic [jbr_pkg::SAMPLE_W-1:0]    in_pcm,
    input  logic                            in_last,
    input  logic                            in_first,
    output logic                            wr_en,
    output logic [jbr_pkg::PTR_W-1:0]       wr_addr,
    output logic [jbr_pkg::SAMPLE_W-1:0]    wr_data,
    output logic                            rd_en,
    output logic [jbr_pkg::PTR_W-1:0]       rd_addr0,
    output logic [jbr_pkg::PTR_W-1:0]       rd_addr1,
    output jbr_pkg::item_info_t             item,
    output jbr_pkg::ctrl_status_t           status
);
    import jbr_pkg::*;

    logic [STEP_W-1:0]  step_nom_reg, step_slow_reg, step_fast_reg;
    logic [LVL_W-1:0]   low_fill_reg, high_fill_reg, prebuf_reg;

    logic [PTR_W-1:0]   rp_reg, rp_next;
    logic [PTR_W-1:0]   wp_reg, wp_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic               primed_reg, primed_next;
    logic               active_reg, active_next;
    logic [STEP_W-1:0]  bstep_reg, bstep_next;

    logic               full;
    logic [CNT_W-1:0]   fill_push;
    logic [PTR_W-1:0]   rp_inc;
    logic               has_two;
    logic               blk_on;
    logic [STEP_W-1:0]  sel_step;
    logic [STEP_W-1:0]  step_use;
    logic [PHASE_W-1:0] ph_sum;
    logic [INT_W-1:0]   ph_int;
    logic [CNT_W-1:0]   fill_m1;
    logic [CNT_W-1:0]   k;
    logic [PTR_W:0]     rp_sum;
    logic [PTR_W-1:0]   rp_adv;
    logic               out_valid_c;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_nom_reg  <= STEP_NOMINAL_RST;
            step_slow_reg <= STEP_SLOW_RST;
            step_fast_reg <= STEP_FAST_RST;
            low_fill_reg  <= LOW_FILL_RST;
            high_fill_reg <= HIGH_FILL_RST;
            prebuf_reg    <= PREBUFFER_LEVEL_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_STEP_NOMINAL:    step_nom_reg  <= cfg_wdata[STEP_W-1:0];
                REG_STEP_SLOW:       step_slow_reg <= cfg_wdata[STEP_W-1:0];
                REG_STEP_FAST:       step_fast_reg <= cfg_wdata[STEP_W-1:0];
                REG_LOW_FILL:        low_fill_reg  <= cfg_wdata[LVL_W-1:0];
                REG_HIGH_FILL:       high_fill_reg <= cfg_wdata[LVL_W-1:0];
                REG_PREBUFFER_LEVEL: prebuf_reg    <= cfg_wdata[LVL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        rp_next     = rp_reg;
        wp_next     = wp_reg;
        fill_next   = fill_reg;
        phase_next  = phase_reg;
        primed_next = primed_reg;
        active_next = active_reg;
        bstep_next  = bstep_reg;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        out_valid_c = 1'b0;

        // push path: drop the oldest word when the ring is full
        full      = (fill_reg == CNT_W'(CAPACITY));
        fill_push = (full ? CNT_W'(CAPACITY - 1) : fill_reg) + CNT_W'(1);
        rp_inc    = next_ptr(rp_reg);

        // output path
        has_two  = (fill_reg >= CNT_W'(2));
        blk_on   = in_first ? (primed_reg && has_two) : active_reg;
        if (CMP_W'(fill_reg) < CMP_W'(low_fill_reg)) begin
            sel_step = step_slow_reg;
        end else if (CMP_W'(fill_reg) > CMP_W'(high_fill_reg)) begin
            sel_step = step_fast_reg;
        end else begin
            sel_step = step_nom_reg;
        end
        step_use = in_first ? sel_step : bstep_reg;
        ph_sum   = phase_reg + PHASE_W'(step_use);
        ph_int   = ph_sum[PHASE_W-1:FRAC_BITS];
        fill_m1  = fill_reg - CNT_W'(1);
        // whole samples consumed, limited so one sample stays buffered
        k        = (ph_int > INT_W'(fill_m1)) ? fill_m1 : CNT_W'(ph_int);
        rp_sum   = {1'b0, rp_reg} + (PTR_W+1)'(k);
        rp_adv   = (rp_sum >= (PTR_W+1)'(CAPACITY)) ?
                   PTR_W'(rp_sum - (PTR_W+1)'(CAPACITY)) : rp_sum[PTR_W-1:0];

        if (in_accept) begin
            if (in_action == ACT_PUSH) begin
                wr_en     = 1'b1;
                wp_next   = next_ptr(wp_reg);
                fill_next = fill_push;
                if (full) begin
                    rp_next = rp_inc;
                end
                if (in_last && (CMP_W'(fill_push) >= CMP_W'(prebuf_reg))) begin
                    primed_next = 1'b1;
                end
            end else begin
                rd_en = 1'b1;
                if (in_first) begin
                    active_next = blk_on;
                    if (blk_on) begin
                        bstep_next = sel_step;
                    end
                end
                if (blk_on) begin
                    if (!has_two) begin
                        // underrun: playback starts over
                        rp_next     = '0;
                        wp_next     = '0;
                        fill_next   = '0;
                        phase_next  = '0;
                        primed_next = 1'b0;
                        active_next = 1'b0;
                    end else begin
                        out_valid_c = 1'b1;
                        phase_next  = ph_sum - (PHASE_W'(k) << FRAC_BITS);
                        rp_next     = rp_adv;
                        fill_next   = fill_reg - k;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rp_reg     <= '0;
            wp_reg     <= '0;
            fill_reg   <= '0;
            phase_reg  <= '0;
            primed_reg <= 1'b0;
            active_reg <= 1'b0;
            bstep_reg  <= '0;
        end else begin
            rp_reg     <= rp_next;
            wp_reg     <= wp_next;
            fill_reg   <= fill_next;
            phase_reg  <= phase_next;
            primed_reg <= primed_next;
            active_reg <= active_next;
            bstep_reg  <= bstep_next;
        end
    end

    assign wr_addr  = wp_reg;
    assign wr_data  = in_pcm;
    assign rd_addr0 = rp_reg;
    assign rd_addr1 = rp_inc;

    assign item.valid  = out_valid_c;
    assign item.phase  = phase_reg;
    assign item.fill   = LVL_W'(fill_next);
    assign item.primed = primed_next;

    assign status.fill         = fill_reg;
    assign status.primed       = primed_reg;
    assign status.block_active = active_reg;

endmodule

/* src/jbr_interp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jbr_interp
// Interpolation pipeline: multiply, truncate and saturate, output register.
// ----------------------------------------------------------------------------
module jbr_interp (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_accept,
    input  jbr_pkg::item_info_t            item,
    input  logic [jbr_pkg::SAMPLE_W-1:0]   rd_data0,
    input  logic [jbr_pkg::SAMPLE_W-1:0]   rd_data1,
    output logic                           in_ready,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic                           out_valid,
    output logic [jbr_pkg::SAMPLE_W-1:0]   out_sample,
    output logic [jbr_pkg::LVL_W-1:0]      out_fill,
    output logic                           out_primed
);
    import jbr_pkg::*;

    // stage 1: ring data arrives
    logic               p1_v_reg, p1_v_next;
    item_info_t         p1_info_reg;

    // stage 2: product
    logic               p2_v_reg, p2_v_next;
    logic               p2_valid_reg;
    logic [LVL_W-1:0]   p2_fill_reg;
    logic               p2_primed_reg;
    logic [PROD_W-1:0]  p2_prod_reg;
    logic [SAMPLE_W-1:0] p2_s0_reg;
    logic               p2_big_reg;
    logic               p2_dneg_reg;
    logic               p2_dzero_reg;

    // output register
    logic               o_v_reg, o_v_next;
    logic               o_valid_reg;
    logic [SAMPLE_W-1:0] o_sample_reg;
    logic [LVL_W-1:0]   o_fill_reg;
    logic               o_primed_reg;

    logic               o_free, p2_free, p1_free;

    logic signed [DIFF_W-1:0]   diff_c;
    logic signed [MUL_PH_W:0]   ph_lo_c;
    logic signed [PROD_W-1:0]   prod_c;

    logic [PART_W-1:0]  part_c;
    logic               round_up;
    logic [PART_W-1:0]  part_rnd;
    logic [PART_W:0]    sum_c;
    logic               fits;
    logic [SAMPLE_W-1:0] sample_c;

    assign o_free  = !o_v_reg || m_tready;
    assign p2_free = !p2_v_reg || o_free;
    assign p1_free = !p1_v_reg || p2_free;
    assign in_ready = p1_free;

    assign p1_v_next = p1_free ? in_accept : p1_v_reg;
    assign p2_v_next = p2_free ? p1_v_reg : p2_v_reg;
    assign o_v_next  = o_free ? p2_v_reg : o_v_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_v_reg <= 1'b0;
            p2_v_reg <= 1'b0;
            o_v_reg  <= 1'b0;
        end else begin
            p1_v_reg <= p1_v_next;
            p2_v_reg <= p2_v_next;
            o_v_reg  <= o_v_next;
        end
    end

    // difference times the phase bits that matter
    always_comb begin
        diff_c  = $signed({rd_data1[SAMPLE_W-1], rd_data1})
                - $signed({rd_data0[SAMPLE_W-1], rd_data0});
        ph_lo_c = $signed({1'b0, p1_info_reg.phase[MUL_PH_W-1:0]});
        prod_c  = diff_c * ph_lo_c;
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            p1_info_reg <= item;
        end
    end

    always_ff @(posedge aclk) begin
        if (p2_free && p1_v_reg) begin
            p2_valid_reg  <= p1_info_reg.valid;
            p2_fill_reg   <= p1_info_reg.fill;
            p2_primed_reg <= p1_info_reg.primed;
            p2_prod_reg   <= prod_c;
            p2_s0_reg     <= rd_data0;
            p2_big_reg    <= |p1_info_reg.phase[PHASE_W-1:MUL_PH_W];
            p2_dneg_reg   <= diff_c[DIFF_W-1];
            p2_dzero_reg  <= (diff_c == '0);
        end
    end

    // truncate toward zero, add, saturate
    always_comb begin
        part_c   = p2_prod_reg[PROD_W-1:FRAC_BITS];
        round_up = p2_prod_reg[PROD_W-1] && (|p2_prod_reg[FRAC_BITS-1:0]);
        part_rnd = part_c + PART_W'(round_up);
        sum_c    = {{(PART_W-SAMPLE_W+1){p2_s0_reg[SAMPLE_W-1]}}, p2_s0_reg}
                 + {part_rnd[PART_W-1], part_rnd};
        fits     = (&sum_c[PART_W:SAMPLE_W-1]) || !(|sum_c[PART_W:SAMPLE_W-1]);
        if (!p2_valid_reg) begin
            sample_c = '0;
        end else if (p2_big_reg) begin
            // phase far past one: any slope runs off the range
            if (p2_dzero_reg) begin
                sample_c = p2_s0_reg;
            end else begin
                sample_c = p2_dneg_reg ? SAMPLE_MIN : SAMPLE_MAX;
            end
        end else if (fits) begin
            sample_c = sum_c[SAMPLE_W-1:0];
        end else begin
            sample_c = sum_c[PART_W] ? SAMPLE_MIN : SAMPLE_MAX;
        end
    end

    always_ff @(posedge aclk) begin
        if (o_free && p2_v_reg) begin
            o_valid_reg  <= p2_valid_reg;
            o_sample_reg <= sample_c;
            o_fill_reg   <= p2_fill_reg;
            o_primed_reg <= p2_primed_reg;
        end
    end

    assign m_tvalid   = o_v_reg;
    assign out_valid  = o_valid_reg;
    assign out_sample = o_sample_reg;
    assign out_fill   = o_fill_reg;
    assign out_primed = o_primed_reg;

endmodule
